// ----- src/assert_macros.svh -----
// Assertion macros for the RTL; the query unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/bfwq_pkg.sv -----
// ---------------------------------------------------------------------------
// bfwq_pkg
// Shared types and constants of the Bloom filter word query unit.
// ---------------------------------------------------------------------------
package bfwq_pkg;
  localparam int unsigned FILTER_DEPTH = 8192;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned HASH_COUNT = 5;
  localparam int unsigned BLOOM_BITS_DEF = 65536;
  localparam int unsigned NUM_HASHES_DEF = 5;

  localparam logic [31:0] FNV_SEED = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] DJB_SEED = 32'd5381;
  localparam logic [31:0] MUR_SEED = 32'h9747b28c;
  localparam logic [31:0] MUR_MULT = 32'h5bd1e995;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIN,
    ST_RED,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_OUT
  } state_t;
endpackage

// ----- src/bfwq_ram.sv -----
// ---------------------------------------------------------------------------
// bfwq_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module bfwq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- src/bloom_filter_word_query_unit.sv -----
// Load word: written to the filter RAM when accepted. Query char, not last:
// accept, multiply, merge. Last char: the same, then per hash a reciprocal
// multiply, a remainder, one filter RAM read and a bit test; a miss ends
// the word early. Result held in an output register until taken.
// Reset (rst, synchronous): accumulators reseeded, output cleared; the filter
// RAM is not cleared and is undefined until loaded.
// ---------------------------------------------------------------------------
// bloom_filter_word_query_unit
// Hashes query characters and tests the resulting bits in the filter RAM.
// ---------------------------------------------------------------------------
module bloom_filter_word_query_unit #(
  parameter int unsigned BLOOM_BITS = bfwq_pkg::BLOOM_BITS_DEF,
  parameter int unsigned NUM_HASHES = bfwq_pkg::NUM_HASHES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [bfwq_pkg::ADDR_W-1:0] filter_addr,
  input  logic [7:0]                data_byte,
  input  logic                      last_char,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      probably_present
);
  import bfwq_pkg::*;

  localparam int unsigned PW = $clog2(BLOOM_BITS);
  localparam int unsigned HW = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  // Reciprocal of BLOOM_BITS for the modulo: floor(2^32*(2^PW-B)/B) + 1.
  localparam logic [63:0] RECIP64 =
    ((64'd1 << 32) * ((64'd1 << PW) - 64'(BLOOM_BITS))) / 64'(BLOOM_BITS) + 64'd1;
  localparam logic [31:0] RECIP = RECIP64[31:0];

  state_t state, state_next;
  logic [31:0] acc [HASH_COUNT];
  logic [31:0] fnv_p, mur_p;     // registered products
  logic [7:0]  chr;
  logic        last_q;
  logic [HW-1:0] idx;
  logic [31:0] fin;              // hash being tested
  logic [31:0] recip_hi;         // high word of hash times reciprocal
  logic [PW-1:0] pos;
  logic        res;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_rdata;

  bfwq_ram #(.WIDTH(8), .DEPTH(FILTER_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(data_byte), .rdata(ram_rdata)
  );

  wire in_acc = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign ram_we = in_acc && (opcode == OP_LOAD);

  // Byte index of the bit: wraps onto the array.
  logic [31:0] byte_ix;
  always_comb begin
    byte_ix = 32'({pos} >> 3);
    ram_addr = ram_we ? filter_addr : byte_ix[ADDR_W-1:0];
  end

  // Bit of the fetched byte, LSB first.
  wire bit_ok = ram_rdata[pos[2:0]];

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && opcode == OP_QUERY) state_next = ST_MUL;
      ST_MUL:   state_next = ST_FIN;
      ST_FIN:   state_next = last_q ? ST_RED : ST_IDLE;
      ST_RED:   state_next = ST_MOD;
      ST_MOD:   state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (!bit_ok || 32'(idx) + 1 >= NUM_HASHES) state_next = ST_OUT;
        else state_next = ST_RED;
      end
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic [31:0] j1, j2, j3, jf;
  always_comb begin
    j1 = acc[3] + (acc[3] << 3);
    j2 = j1 ^ (j1 >> 11);
    j3 = j2 + (j2 << 15);
    jf = j3;
  end

  // Modulo by BLOOM_BITS: quotient by reciprocal multiplication, then the
  // remainder. Reduces to a shift and a mask when BLOOM_BITS is a power of two.
  logic [63:0] recip_prod;
  logic [31:0] quo;
  logic [31:0] rem;
  always_comb begin
    recip_prod = 64'(acc[idx]) * 64'(RECIP);
    quo = (recip_hi + ((fin - recip_hi) >> 1)) >> (PW - 1);
    rem = fin - quo * 32'(BLOOM_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc[0] <= FNV_SEED;
      acc[1] <= DJB_SEED + 32'd1;
      acc[2] <= 32'd2;
      acc[3] <= 32'd3;
      acc[4] <= MUR_SEED + 32'd4;
      idx <= '0;
      res <= 1'b0;
    end else begin
      priority case (state)
        ST_IDLE: begin
          if (in_acc && opcode == OP_QUERY) begin
            chr <= data_byte;
            last_q <= last_char;
            // simple accumulators now, multiplies next cycle
            acc[1] <= (acc[1] << 5) + acc[1] + {24'd0, data_byte};
            acc[2] <= {24'd0, data_byte} + (acc[2] << 6) + (acc[2] << 16) - acc[2];
            begin
              logic [31:0] t;
              t = acc[3] + {24'd0, data_byte};
              t = t + (t << 10);
              acc[3] <= t ^ (t >> 6);
            end
          end
        end
        ST_MUL: begin
          fnv_p <= (acc[0] ^ {24'd0, chr}) * FNV_PRIME;
          mur_p <= (acc[4] ^ {24'd0, chr}) * MUR_MULT;
        end
        ST_FIN: begin
          acc[0] <= fnv_p;
          acc[4] <= mur_p ^ (mur_p >> 15);
          idx <= '0;
          if (last_q) acc[3] <= jf;
        end
        ST_RED: begin
          fin <= acc[idx];
          recip_hi <= recip_prod[63:32];
        end
        ST_MOD: begin
          pos <= rem[PW-1:0];
        end
        ST_READ: ;
        ST_CHECK: begin
          idx <= idx + 1'b1;
          if (!bit_ok || 32'(idx) + 1 >= NUM_HASHES) begin
            res <= bit_ok;
            // reseed for the next word
            acc[0] <= FNV_SEED;
            acc[1] <= DJB_SEED + 32'd1;
            acc[2] <= 32'd2;
            acc[3] <= 32'd3;
            acc[4] <= MUR_SEED + 32'd4;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_OUT);
  assign probably_present = res;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_in_busy, clk, rst, state != ST_IDLE, in_stall, "input taken while busy")
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(res),
               "result dropped while stalled")
  `ASSERT_IMPL(a_idx_rng, clk, rst, state == ST_CHECK, 32'(idx) < NUM_HASHES,
               "hash index beyond count")
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bloom filter word query unit: loads filter bytes
// and queries words; each answer is predicted in-bench or taken from the directed table.
// ---------------------------------------------------------------------------
module testbench;
  import bfwq_pkg::*;

  typedef logic [HASH_COUNT-1:0][31:0] hash_vec_t;
  typedef enum int {FILL_NONE, FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              last;
    fill_t             fill;  // how to prepare the bytes the word will hit
    int                want;  // typed answer, or -1 to take the prediction
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              opcode = OP_LOAD;
  logic [ADDR_W-1:0] filter_addr = '0;
  logic [7:0]        data_byte = 8'h00;
  logic              last_char = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              probably_present;

  // Shadow copy of the block: filter bytes, which ones hold data, and hashes.
  logic [7:0]        shadow_filter [FILTER_DEPTH];
  bit                shadow_written [FILTER_DEPTH];
  hash_vec_t         shadow_hash;
  logic [15:0]       word_bit_pos [HASH_COUNT];

  bit                answers_due [$];
  int                errors = 0;
  int                items_sent = 0;
  int                idle_cycles = 0;
  bit                burst_mode = 1'b0;

  stim_row_t         directed [] = '{
    '{OP_LOAD,  13'h0000, 8'hff, 1'b0, FILL_NONE, -1},
    '{OP_LOAD,  13'h1fff, 8'h00, 1'b1, FILL_NONE, -1},  // last flag ignored
    '{OP_LOAD,  13'h1555, 8'haa, 1'b0, FILL_NONE, -1},
    '{OP_LOAD,  13'h0aaa, 8'h55, 1'b1, FILL_NONE, -1},
    '{OP_QUERY, 13'h0000, 8'h61, 1'b1, FILL_ONES,  1},
    '{OP_QUERY, 13'h1fff, 8'h00, 1'b1, FILL_ZERO,  0},  // NUL hashed as a char
    '{OP_QUERY, 13'h0000, 8'hff, 1'b1, FILL_ONES,  1},
    '{OP_QUERY, 13'h0000, 8'h00, 1'b1, FILL_ONES,  1},
    '{OP_QUERY, 13'h0000, 8'h61, 1'b0, FILL_NONE, -1},
    '{OP_LOAD,  13'h0064, 8'h3c, 1'b1, FILL_NONE, -1},  // load mid-word
    '{OP_QUERY, 13'h0000, 8'h62, 1'b1, FILL_ZERO,  0},
    '{OP_QUERY, 13'h1fff, 8'h80, 1'b0, FILL_NONE, -1},
    '{OP_QUERY, 13'h0000, 8'h7f, 1'b0, FILL_NONE, -1},
    '{OP_QUERY, 13'h1fff, 8'h01, 1'b1, FILL_RAND, -1},
    '{OP_QUERY, 13'h0000, 8'hff, 1'b0, FILL_NONE, -1},
    '{OP_QUERY, 13'h0000, 8'hff, 1'b1, FILL_ONES,  1}
  };

  bloom_filter_word_query_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .filter_addr      (filter_addr),
    .data_byte        (data_byte),
    .last_char        (last_char),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .probably_present (probably_present)
  );

  always #5 clk = ~clk;

  function automatic hash_vec_t seeded_hashes();
    hash_vec_t h;
    h[0] = FNV_SEED;
    h[1] = DJB_SEED + 32'd1;
    h[2] = 32'd2;
    h[3] = 32'd3;
    h[4] = MUR_SEED + 32'd4;
    return h;
  endfunction

  // Fold one character into all five running hashes, 32-bit wraparound.
  function automatic hash_vec_t hash_char(hash_vec_t h, logic [7:0] ch);
    logic [31:0] c;
    logic [31:0] t;
    c = {24'd0, ch};
    h[0] = (h[0] ^ c) * FNV_PRIME;
    h[1] = (h[1] << 5) + h[1] + c;
    h[2] = c + (h[2] << 6) + (h[2] << 16) - h[2];
    t = h[3] + c;
    t = t + (t << 10);
    h[3] = t ^ (t >> 6);
    t = (h[4] ^ c) * MUR_MULT;
    h[4] = t ^ (t >> 15);
    return h;
  endfunction

  // Finalise the one-at-a-time hash and reduce every hash to a bit position.
  task automatic bit_positions(input hash_vec_t h);
    logic [31:0] j;
    j = h[3];
    j = j + (j << 3);
    j = j ^ (j >> 11);
    j = j + (j << 15);
    h[3] = j;
    for (int k = 0; k < HASH_COUNT; k++) begin
      word_bit_pos[k] = 16'(h[k] % BLOOM_BITS_DEF);
    end
  endtask

  function automatic bit filter_hit();
    for (int k = 0; k < NUM_HASHES_DEF; k++) begin
      if (!shadow_filter[word_bit_pos[k][15:3]][word_bit_pos[k][2:0]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    errors++;
  endtask

  // Present one word on the input channel, hold it until taken, then advance
  // the shadow state. Leaves time at the accepting edge.
  task automatic push_word(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] data, input logic last, input int want);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    filter_addr <= addr;
    data_byte   <= data;
    last_char   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_LOAD) begin
      shadow_filter[addr]  = data;
      shadow_written[addr] = 1'b1;
    end else begin
      shadow_hash = hash_char(shadow_hash, data);
      if (last) begin
        bit_positions(shadow_hash);
        answers_due.push_back(want >= 0 ? want[0] : filter_hit());
        shadow_hash = seeded_hashes();
      end
    end
  endtask

  // Before the last character goes in, load the bytes it will hit so that no
  // unloaded byte is ever read, shaping them towards a hit or a miss.
  task automatic prepare_bytes(input logic [7:0] ch, input fill_t fill);
    logic [12:0] idx;
    logic [7:0]  val;
    bit_positions(hash_char(shadow_hash, ch));
    for (int k = 0; k < HASH_COUNT; k++) begin
      idx = word_bit_pos[k][15:3];
      val = shadow_written[idx] ? shadow_filter[idx] : 8'($urandom);
      case (fill)
        FILL_ZERO: val = 8'h00;
        FILL_ONES: val = val | (8'h01 << word_bit_pos[k][2:0]);
        default: ;
      endcase
      if (!shadow_written[idx] || val != shadow_filter[idx] || fill == FILL_ZERO) begin
        push_word(OP_LOAD, idx, val, 1'($urandom_range(0, 1)), -1);
      end
    end
  endtask

  // Result side: stall a random while unless in burst mode, then take the next answer and check it.
  initial begin
    int hold;
    bit want;
    @(negedge rst);
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", -1, probably_present);
      end else begin
        want = answers_due.pop_front();
        if (probably_present !== want) report_mismatch("probably_present", want, probably_present);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int chars;
    fill_t fill;
    logic [7:0] ch;
    bit paused;
    paused = 1'b0;
    shadow_hash = seeded_hashes();
    for (int i = 0; i < FILTER_DEPTH; i++) shadow_written[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table: extremes, mid-word loads, forced hits and misses.
    foreach (directed[r]) begin
      if (directed[r].op == OP_QUERY && directed[r].last)
        prepare_bytes(directed[r].data, directed[r].fill);
      push_word(directed[r].op, directed[r].addr, directed[r].data,
                directed[r].last, directed[r].want);
    end

    // Random words, with stray loads mixed in; bursts with no idling at times.
    while (items_sent < 850) begin
      if ($urandom_range(0, 7) == 0) burst_mode = ~burst_mode;
      if (!paused && items_sent > 400) begin
        // Hold off until every answer is back.
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
      end
      chars = $urandom_range(1, 8);
      fill  = $urandom_range(0, 1) ? FILL_ONES : FILL_RAND;
      for (int c = 0; c < chars; c++) begin
        ch = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h7a));
        if ($urandom_range(0, 9) == 0)
          push_word(OP_LOAD, 13'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), -1);
        if (c == chars - 1) prepare_bytes(ch, fill);
        push_word(OP_QUERY, 13'($urandom), ch, c == chars - 1, -1);
      end
    end

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
